### rtl/bps_pkg.sv
// Shared constants, status and register codes, and the arctangent table
// for the ballistic pitch solver. No dependencies.
package bps_pkg;

  localparam int ANGLE_ITERATIONS_DEF = 16;
  localparam int ATAN_ENTRIES = 24;

  localparam int CW = 44;
  localparam int ZW = 26;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_UNREACH = 2'd2;
  localparam logic [1:0] ST_LIMIT   = 2'd3;

  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_GRAVITY   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_PITCH_MIN = 2'd1;
  localparam logic [CFG_AW-1:0] REG_PITCH_MAX = 2'd2;

  localparam logic [15:0] GRAVITY_RST = 16'd9810;
  localparam logic signed [14:0] PITCH_MIN_RST = -15'sd9000;
  localparam logic signed [14:0] PITCH_MAX_RST = 15'sd9000;

  localparam logic [56:0] PI_Q40 = 57'h3243F6A8885;
  localparam logic [56:0] LIM_HALF = 57'd150994944000;
  localparam logic [32:0] LIM_DEN = 33'd18000;
  localparam logic [63:0] LIM_RECIP_W = (64'd1 << 46) / 64'd18000;
  localparam logic [31:0] LIM_RECIP = LIM_RECIP_W[31:0];

  localparam logic [27:0] TIME_FIVE12 = 28'd244140625;
  localparam int TIME_W = 24;

  function automatic logic [23:0] atan_q24(input logic [4:0] idx);
    logic [23:0] r;
    unique case (idx)
      5'd0:  r = 24'd13176795;
      5'd1:  r = 24'd7778716;
      5'd2:  r = 24'd4110060;
      5'd3:  r = 24'd2086331;
      5'd4:  r = 24'd1047214;
      5'd5:  r = 24'd524117;
      5'd6:  r = 24'd262123;
      5'd7:  r = 24'd131069;
      5'd8:  r = 24'd65536;
      5'd9:  r = 24'd32768;
      5'd10: r = 24'd16384;
      5'd11: r = 24'd8192;
      5'd12: r = 24'd4096;
      5'd13: r = 24'd2048;
      5'd14: r = 24'd1024;
      5'd15: r = 24'd512;
      5'd16: r = 24'd256;
      5'd17: r = 24'd128;
      5'd18: r = 24'd64;
      5'd19: r = 24'd32;
      5'd20: r = 24'd16;
      5'd21: r = 24'd8;
      5'd22: r = 24'd4;
      5'd23: r = 24'd2;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/ballistic_pitch_solver.sv
// Top level of the drag-free ballistic pitch solver: config registers,
// arithmetic pipeline, limit conversion and output register.
// Depends on bps_pkg, bps_sqrt and bps_cordic.
//
//   port group    dir   word / handshake
//   cfg_*         in    cfg_we, cfg_addr, cfg_data: register write, no wait
//   item_*        in    distance, height, speed under item_valid/item_ready
//   result_*      out   status, pitch, flight_time under result_valid/result_ready
//
// One word enters per cycle while item_ready is high; the path runs through
// the two bit-serial root pipelines, the CORDIC lanes and the 24-stage divider.
// Reset clears valid bits and loads register defaults; no clearing pass.
// A stalled result holds the pipeline only while its last stage holds a word;
// otherwise all stages advance. Pitch limits settle via registers l1-l4 and lq.
module ballistic_pitch_solver import bps_pkg::*; #(
  parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [15:0]         cfg_data,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [15:0]         distance,
  input  logic signed [15:0]  height,
  input  logic [15:0]         speed,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [1:0]          status,
  output logic signed [17:0]  pitch,
  output logic [TIME_W-1:0]   flight_time
);

  localparam int YW = 35;
  localparam int DIV_STAGES = TIME_W;
  localparam int SQ1_SIDE = 98;
  localparam int CA_SIDE = 2 + 32 + 32 + YW;
  localparam int SQ2_SIDE = 52;

  function automatic logic [5:0] norm_shift(input logic [33:0] m);
    logic [5:0] s;
    s = 6'd0;
    for (int i = 0; i < 34; i++) begin
      if (m[i]) s = 6'(39 - i);
    end
    return s;
  endfunction

  logic [15:0]        gravity;
  logic signed [14:0] pitch_min;
  logic signed [14:0] pitch_max;
  logic signed [18:0] lim_lo;
  logic signed [18:0] lim_hi;

  logic adv;
  logic out_load;
  logic fin_v;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity   <= GRAVITY_RST;
      pitch_min <= PITCH_MIN_RST;
      pitch_max <= PITCH_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GRAVITY:   gravity   <= cfg_data;
        REG_PITCH_MIN: pitch_min <= cfg_data[14:0];
        REG_PITCH_MAX: pitch_max <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // centidegree limits to Q16 radians
  for (genvar li = 0; li < 2; li++) begin : g_lim
    logic signed [14:0] c;
    logic [14:0]        a;
    logic [56:0]        num;
    logic [63:0]        prod;
    logic [32:0]        rem;
    logic               l1_neg, l2_neg, l3_neg, l4_neg;
    logic [31:0]        l1_n, l2_n, l3_n;
    logic [17:0]        l2_q, l3_q, l4_q;
    logic [32:0]        l3_t;
    logic signed [18:0] lq;

    assign c    = (li == 0) ? pitch_min : pitch_max;
    assign a    = c[14] ? 15'(-c) : 15'(c);
    assign num  = 57'(a) * PI_Q40 + LIM_HALF;
    assign prod = 64'(l1_n) * 64'(LIM_RECIP);
    assign rem  = {1'b0, l3_n} - l3_t;

    always_ff @(posedge clk) begin
      l1_neg <= c[14];
      l1_n   <= num[55:24];
      l2_neg <= l1_neg;
      l2_n   <= l1_n;
      l2_q   <= prod[63:46];
      l3_neg <= l2_neg;
      l3_n   <= l2_n;
      l3_q   <= l2_q;
      l3_t   <= 33'(l2_q) * LIM_DEN;
      l4_neg <= l3_neg;
      l4_q   <= (rem >= LIM_DEN) ? l3_q + 18'd1 : l3_q;
      lq     <= l4_neg ? -signed'({1'b0, l4_q}) : signed'({1'b0, l4_q});
    end

    if (li == 0) begin : g_lo
      assign lim_lo = lq;
    end else begin : g_hi
      assign lim_hi = lq;
    end
  end

  assign out_load   = !result_valid || result_ready;
  assign adv        = out_load || !fin_v;
  assign item_ready = adv;

  // S1: capture
  logic               s1_v;
  logic [15:0]        s1_dist, s1_spd;
  logic signed [15:0] s1_hgt;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= item_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dist <= distance;
      s1_hgt  <= height;
      s1_spd  <= speed;
    end
  end

  // S2: first products
  logic        s2_v, s2_hneg, s2_bad;
  logic [31:0] s2_v2, s2_gd, s2_gv;
  logic [32:0] s2_gh1;
  logic [15:0] habs;

  assign habs = s1_hgt[15] ? 16'(-s1_hgt) : 16'(s1_hgt);

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_v2   <= 32'(s1_spd) * 32'(s1_spd);
      s2_gd   <= 32'(gravity) * 32'(s1_dist);
      s2_gv   <= 32'(gravity) * 32'(s1_spd);
      s2_gh1  <= 33'({gravity, 1'b0}) * 33'(habs);
      s2_hneg <= s1_hgt[15];
      s2_bad  <= (s1_dist == 16'd0) || (s1_spd == 16'd0) || (gravity == 16'd0);
    end
  end

  // S3: squares
  logic        s3_v, s3_hneg, s3_bad;
  logic [63:0] s3_v4, s3_gd2;
  logic [64:0] s3_gh;
  logic [31:0] s3_v2, s3_gd, s3_gv;

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= s2_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_v4   <= 64'(s2_v2) * 64'(s2_v2);
      s3_gd2  <= 64'(s2_gd) * 64'(s2_gd);
      s3_gh   <= 65'(s2_gh1) * 65'(s2_v2);
      s3_v2   <= s2_v2;
      s3_gd   <= s2_gd;
      s3_gv   <= s2_gv;
      s3_hneg <= s2_hneg;
      s3_bad  <= s2_bad;
    end
  end

  // S4: discriminant terms
  logic        s4_v, s4_bad;
  logic [65:0] s4_pos, s4_neg;
  logic [31:0] s4_v2, s4_gd, s4_gv;

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (adv) s4_v <= s3_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_pos <= s3_hneg ? 66'(s3_v4) + 66'(s3_gh) : 66'(s3_v4);
      s4_neg <= s3_hneg ? 66'(s3_gd2) : 66'(s3_gd2) + 66'(s3_gh);
      s4_v2  <= s3_v2;
      s4_gd  <= s3_gd;
      s4_gv  <= s3_gv;
      s4_bad <= s3_bad;
    end
  end

  // S5: discriminant
  logic        s5_v;
  logic [65:0] s5_d;
  logic [1:0]  s5_st;
  logic [31:0] s5_v2, s5_gd, s5_gv;
  logic [66:0] diff;

  assign diff = {1'b0, s4_pos} - {1'b0, s4_neg};

  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (adv) s5_v <= s4_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_d  <= diff[65:0];
      s5_st <= s4_bad ? ST_BAD : (diff[66] ? ST_UNREACH : ST_OK);
      s5_v2 <= s4_v2;
      s5_gd <= s4_gd;
      s5_gv <= s4_gv;
    end
  end

  logic                q1_v;
  logic [32:0]         q1_root;
  logic [SQ1_SIDE-1:0] q1_tag;

  bps_sqrt #(.IN_W(66), .SIDE_W(SQ1_SIDE)) u_sqrt_disc (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .arg_valid (s5_v),
    .radicand  (s5_d),
    .tag       ({s5_st, s5_v2, s5_gd, s5_gv}),
    .res_valid (q1_v),
    .root      (q1_root),
    .res_tag   (q1_tag)
  );

  // S6: root numerators
  logic                 s6_v;
  logic signed [YW-1:0] s6_y1, s6_y2;
  logic [1:0]           s6_st;
  logic [31:0]          s6_gd, s6_gv;

  always_ff @(posedge clk) begin
    if (rst) s6_v <= 1'b0;
    else if (adv) s6_v <= q1_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_y1 <= signed'(YW'(q1_tag[95:64]) + YW'(q1_root));
      s6_y2 <= signed'(YW'(q1_tag[95:64]) - YW'(q1_root));
      s6_st <= q1_tag[97:96];
      s6_gd <= q1_tag[63:32];
      s6_gv <= q1_tag[31:0];
    end
  end

  // S7: normalize shift
  logic                 s7_v;
  logic signed [YW-1:0] s7_y1, s7_y2;
  logic [5:0]           s7_sh1, s7_sh2;
  logic [1:0]           s7_st;
  logic [31:0]          s7_gd, s7_gv;
  logic [33:0]          y2abs6, mag1, mag2;

  assign y2abs6 = s6_y2[YW-1] ? 34'(-s6_y2) : 34'(s6_y2);
  assign mag1   = (34'(s6_gd) > s6_y1[33:0]) ? 34'(s6_gd) : s6_y1[33:0];
  assign mag2   = (34'(s6_gd) > y2abs6) ? 34'(s6_gd) : y2abs6;

  always_ff @(posedge clk) begin
    if (rst) s7_v <= 1'b0;
    else if (adv) s7_v <= s6_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_sh1 <= norm_shift(mag1);
      s7_sh2 <= norm_shift(mag2);
      s7_y1  <= s6_y1;
      s7_y2  <= s6_y2;
      s7_st  <= s6_st;
      s7_gd  <= s6_gd;
      s7_gv  <= s6_gv;
    end
  end

  // S8: normalize
  logic                 s8_v;
  logic signed [CW-1:0] s8_x1, s8_x2, s8_ya, s8_yb;
  logic signed [YW-1:0] s8_y1, s8_y2;
  logic [1:0]           s8_st;
  logic [31:0]          s8_gd, s8_gv;

  always_ff @(posedge clk) begin
    if (rst) s8_v <= 1'b0;
    else if (adv) s8_v <= s7_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s8_x1 <= signed'(CW'(s7_gd) << s7_sh1);
      s8_x2 <= signed'(CW'(s7_gd) << s7_sh2);
      s8_ya <= CW'(s7_y1) <<< s7_sh1;
      s8_yb <= CW'(s7_y2) <<< s7_sh2;
      s8_y1 <= s7_y1;
      s8_y2 <= s7_y2;
      s8_st <= s7_st;
      s8_gd <= s7_gd;
      s8_gv <= s7_gv;
    end
  end

  logic                 ca_v, cb_v;
  logic signed [ZW-1:0] za, zb;
  logic [CA_SIDE-1:0]   ca_tag;
  logic [YW-1:0]        cb_tag;

  bps_cordic #(.ITER(ANGLE_ITERATIONS), .SIDE_W(CA_SIDE)) u_cordic_hi (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .arg_valid (s8_v),
    .x         (s8_x1),
    .y         (s8_ya),
    .tag       ({s8_st, s8_gd, s8_gv, s8_y1}),
    .res_valid (ca_v),
    .angle     (za),
    .res_tag   (ca_tag)
  );

  bps_cordic #(.ITER(ANGLE_ITERATIONS), .SIDE_W(YW)) u_cordic_lo (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .arg_valid (s8_v),
    .x         (s8_x2),
    .y         (s8_yb),
    .tag       (s8_y2),
    .res_valid (cb_v),
    .angle     (zb),
    .res_tag   (cb_tag)
  );

  // S9: round angles
  logic                 s9_v;
  logic signed [17:0]   s9_p1, s9_p2;
  logic signed [YW-1:0] s9_y1, s9_y2;
  logic [1:0]           s9_st;
  logic [31:0]          s9_gd, s9_gv;
  logic signed [ZW-1:0] zr1, zr2;

  assign zr1 = za + 26'sd128;
  assign zr2 = zb + 26'sd128;

  always_ff @(posedge clk) begin
    if (rst) s9_v <= 1'b0;
    else if (adv) s9_v <= ca_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s9_p1 <= zr1[ZW-1:8];
      s9_p2 <= zr2[ZW-1:8];
      s9_st <= ca_tag[CA_SIDE-1 -: 2];
      s9_gd <= ca_tag[YW+63:YW+32];
      s9_gv <= ca_tag[YW+31:YW];
      s9_y1 <= ca_tag[YW-1:0];
      s9_y2 <= cb_tag;
    end
  end

  // S10: limit check and choice
  logic               s10_v;
  logic [1:0]         s10_st;
  logic signed [17:0] s10_pitch;
  logic [33:0]        s10_ya;
  logic [31:0]        s10_gd, s10_gv;
  logic               ok1, ok2, take2;
  logic [33:0]        y2abs9;
  logic [1:0]         st10;

  assign ok1    = (s9_p1 >= lim_lo) && (s9_p1 <= lim_hi);
  assign ok2    = (s9_p2 >= lim_lo) && (s9_p2 <= lim_hi);
  assign y2abs9 = s9_y2[YW-1] ? 34'(-s9_y2) : 34'(s9_y2);
  assign take2  = (ok1 && ok2) ? (y2abs9 < s9_y1[33:0]) : ok2;
  assign st10   = (s9_st != ST_OK) ? s9_st : ((!ok1 && !ok2) ? ST_LIMIT : ST_OK);

  always_ff @(posedge clk) begin
    if (rst) s10_v <= 1'b0;
    else if (adv) s10_v <= s9_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s10_st    <= st10;
      s10_pitch <= (st10 == ST_OK) ? (take2 ? s9_p2 : s9_p1) : '0;
      s10_ya    <= take2 ? y2abs9 : s9_y1[33:0];
      s10_gd    <= s9_gd;
      s10_gv    <= s9_gv;
    end
  end

  // S11: path length squares
  logic               s11_v;
  logic [67:0]        s11_ya2;
  logic [63:0]        s11_gd2;
  logic [1:0]         s11_st;
  logic signed [17:0] s11_pitch;
  logic [31:0]        s11_gv;

  always_ff @(posedge clk) begin
    if (rst) s11_v <= 1'b0;
    else if (adv) s11_v <= s10_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s11_ya2   <= 68'(s10_ya) * 68'(s10_ya);
      s11_gd2   <= 64'(s10_gd) * 64'(s10_gd);
      s11_st    <= s10_st;
      s11_pitch <= s10_pitch;
      s11_gv    <= s10_gv;
    end
  end

  // S12: sum
  logic               s12_v;
  logic [68:0]        s12_big;
  logic [1:0]         s12_st;
  logic signed [17:0] s12_pitch;
  logic [31:0]        s12_gv;

  always_ff @(posedge clk) begin
    if (rst) s12_v <= 1'b0;
    else if (adv) s12_v <= s11_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s12_big   <= 69'(s11_ya2) + 69'(s11_gd2);
      s12_st    <= s11_st;
      s12_pitch <= s11_pitch;
      s12_gv    <= s11_gv;
    end
  end

  // S13: scale partial products
  logic               s13_v;
  logic [62:0]        s13_pl;
  logic [61:0]        s13_ph;
  logic [1:0]         s13_st;
  logic signed [17:0] s13_pitch;
  logic [31:0]        s13_gv;

  always_ff @(posedge clk) begin
    if (rst) s13_v <= 1'b0;
    else if (adv) s13_v <= s12_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s13_pl    <= 63'(s12_big[34:0]) * 63'(TIME_FIVE12);
      s13_ph    <= 62'(s12_big[68:35]) * 62'(TIME_FIVE12);
      s13_st    <= s12_st;
      s13_pitch <= s12_pitch;
      s13_gv    <= s12_gv;
    end
  end

  // S14: scaled radicand
  logic               s14_v;
  logic [109:0]       s14_sc;
  logic [1:0]         s14_st;
  logic signed [17:0] s14_pitch;
  logic [31:0]        s14_gv;
  logic [96:0]        sc97;

  assign sc97 = (97'(s13_ph) << 35) + 97'(s13_pl);

  always_ff @(posedge clk) begin
    if (rst) s14_v <= 1'b0;
    else if (adv) s14_v <= s13_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s14_sc    <= {1'b0, sc97, 12'b0};
      s14_st    <= s13_st;
      s14_pitch <= s13_pitch;
      s14_gv    <= s13_gv;
    end
  end

  logic                q2_v;
  logic [54:0]         q2_root;
  logic [SQ2_SIDE-1:0] q2_tag;

  bps_sqrt #(.IN_W(110), .SIDE_W(SQ2_SIDE)) u_sqrt_path (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .arg_valid (s14_v),
    .radicand  (s14_sc),
    .tag       ({s14_st, s14_pitch, s14_gv}),
    .res_valid (q2_v),
    .root      (q2_root),
    .res_tag   (q2_tag)
  );

  // restoring divide by g*v, one quotient bit per stage
  logic               dv_v     [DIV_STAGES];
  logic [55:0]        dv_rem   [DIV_STAGES];
  logic [TIME_W-1:0]  dv_q     [DIV_STAGES];
  logic [31:0]        dv_gv    [DIV_STAGES];
  logic [1:0]         dv_st    [DIV_STAGES];
  logic signed [17:0] dv_pitch [DIV_STAGES];
  logic               dv_sat   [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic               v_s, sat_s, ge;
    logic [55:0]        rem_s, dvsr;
    logic [TIME_W-1:0]  q_s;
    logic [31:0]        gv_s;
    logic [1:0]         st_s;
    logic signed [17:0] p_s;

    if (k == 0) begin : g_first
      assign v_s   = q2_v;
      assign rem_s = 56'(q2_root);
      assign q_s   = '0;
      assign gv_s  = q2_tag[31:0];
      assign p_s   = q2_tag[49:32];
      assign st_s  = q2_tag[51:50];
      assign sat_s = 56'(q2_root) >= {q2_tag[31:0], 24'b0};
    end else begin : g_next
      assign v_s   = dv_v[k-1];
      assign rem_s = dv_rem[k-1];
      assign q_s   = dv_q[k-1];
      assign gv_s  = dv_gv[k-1];
      assign p_s   = dv_pitch[k-1];
      assign st_s  = dv_st[k-1];
      assign sat_s = dv_sat[k-1];
    end

    assign dvsr = 56'(gv_s) << (DIV_STAGES - 1 - k);
    assign ge   = rem_s >= dvsr;

    always_ff @(posedge clk) begin
      if (rst) dv_v[k] <= 1'b0;
      else if (adv) dv_v[k] <= v_s;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[k]   <= ge ? rem_s - dvsr : rem_s;
        dv_q[k]     <= {q_s[TIME_W-2:0], ge};
        dv_gv[k]    <= gv_s;
        dv_pitch[k] <= p_s;
        dv_st[k]    <= st_s;
        dv_sat[k]   <= sat_s;
      end
    end
  end

  assign fin_v = dv_v[DIV_STAGES-1];

  // output register
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (out_load) result_valid <= fin_v;
  end
  always_ff @(posedge clk) begin
    if (out_load) begin
      status <= dv_st[DIV_STAGES-1];
      pitch  <= dv_pitch[DIV_STAGES-1];
      if (dv_st[DIV_STAGES-1] != ST_OK) flight_time <= '0;
      else if (dv_sat[DIV_STAGES-1]) flight_time <= '1;
      else flight_time <= dv_q[DIV_STAGES-1];
    end
  end

  a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (result_valid && !result_ready))
    else $error("input held while output free");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    ca_v == cb_v)
    else $error("angle lanes out of step");

  a_unsolved_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_OK) |-> (pitch == '0 && flight_time == '0))
    else $error("unsolved word carries pitch or time");

endmodule

### rtl/bps_sqrt.sv
// Pipelined floor square root, one root bit per stage, with a tag that
// travels alongside. No package dependencies.
module bps_sqrt #(
  parameter int IN_W   = 66,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              arg_valid,
  input  logic [IN_W-1:0]   radicand,
  input  logic [SIDE_W-1:0] tag,
  output logic              res_valid,
  output logic [IN_W/2-1:0] root,
  output logic [SIDE_W-1:0] res_tag
);

  localparam int R  = IN_W / 2;
  localparam int RW = R + 3;

  logic              vld_q  [R];
  logic [RW-1:0]     rem_q  [R];
  logic [R-1:0]      root_q [R];
  logic [IN_W-1:0]   rest_q [R];
  logic [SIDE_W-1:0] tag_q  [R];

  for (genvar k = 0; k < R; k++) begin : g_stage
    logic              v_s;
    logic [RW-1:0]     rem_s;
    logic [R-1:0]      root_s;
    logic [IN_W-1:0]   rest_s;
    logic [SIDE_W-1:0] tag_s;
    logic [RW-1:0]     cur;
    logic [RW-1:0]     trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_s    = arg_valid;
      assign rem_s  = '0;
      assign root_s = '0;
      assign rest_s = radicand;
      assign tag_s  = tag;
    end else begin : g_next
      assign v_s    = vld_q[k-1];
      assign rem_s  = rem_q[k-1];
      assign root_s = root_q[k-1];
      assign rest_s = rest_q[k-1];
      assign tag_s  = tag_q[k-1];
    end

    assign cur   = {rem_s[RW-3:0], rest_s[IN_W-1 -: 2]};
    assign trial = {1'b0, root_s, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? cur - trial : cur;
        root_q[k] <= {root_s[R-2:0], ge};
        rest_q[k] <= {rest_s[IN_W-3:0], 2'b00};
        tag_q[k]  <= tag_s;
      end
    end
  end

  assign res_valid = vld_q[R-1];
  assign root      = root_q[R-1];
  assign res_tag   = tag_q[R-1];

endmodule

### rtl/bps_cordic.sv
// Pipelined CORDIC vectoring lane, one rotation per stage, angle in Q24.
// Depends on bps_pkg for datapath widths and the arctangent table.
module bps_cordic import bps_pkg::*; #(
  parameter int ITER   = ANGLE_ITERATIONS_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 arg_valid,
  input  logic signed [CW-1:0] x,
  input  logic signed [CW-1:0] y,
  input  logic [SIDE_W-1:0]    tag,
  output logic                 res_valid,
  output logic signed [ZW-1:0] angle,
  output logic [SIDE_W-1:0]    res_tag
);

  logic                 vld_q [ITER];
  logic signed [CW-1:0] x_q   [ITER];
  logic signed [CW-1:0] y_q   [ITER];
  logic signed [ZW-1:0] z_q   [ITER];
  logic [SIDE_W-1:0]    tag_q [ITER];

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    logic                 v_s;
    logic signed [CW-1:0] x_s;
    logic signed [CW-1:0] y_s;
    logic signed [ZW-1:0] z_s;
    logic [SIDE_W-1:0]    tag_s;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] at;

    if (i == 0) begin : g_first
      assign v_s   = arg_valid;
      assign x_s   = x;
      assign y_s   = y;
      assign z_s   = '0;
      assign tag_s = tag;
    end else begin : g_next
      assign v_s   = vld_q[i-1];
      assign x_s   = x_q[i-1];
      assign y_s   = y_q[i-1];
      assign z_s   = z_q[i-1];
      assign tag_s = tag_q[i-1];
    end

    assign dx = y_s >>> i;
    assign dy = x_s >>> i;
    assign at = signed'(ZW'(atan_q24(5'(i))));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_q[i] <= tag_s;
        if (!y_s[CW-1]) begin
          x_q[i] <= x_s + dx;
          y_q[i] <= y_s - dy;
          z_q[i] <= z_s + at;
        end else begin
          x_q[i] <= x_s - dx;
          y_q[i] <= y_s + dy;
          z_q[i] <= z_s - at;
        end
      end
    end
  end

  assign res_valid = vld_q[ITER-1];
  assign angle     = z_q[ITER-1];
  assign res_tag   = tag_q[ITER-1];

endmodule

### sim/tb_ballistic_pitch_solver.sv
// Self-checking testbench for ballistic_pitch_solver: directed and random aiming
// requests, random stalls on both sides, several register settings.
// Depends on bps_pkg and the solver RTL.
module tb_ballistic_pitch_solver;
  import bps_pkg::*;

  localparam int CORDIC_STEPS = ANGLE_ITERATIONS_DEF;
  localparam int WD_LIMIT = 5000;

  typedef struct packed {
    logic [15:0] reach;
    logic signed [15:0] hgt;
    logic [15:0] spd;
  } shot_t;

  typedef struct packed {
    logic [1:0] st;
    logic signed [17:0] ang;
    logic [23:0] tof;
  } aim_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [15:0] cfg_data = '0;
  logic item_valid = 0;
  logic item_ready;
  logic [15:0] distance = '0;
  logic signed [15:0] height = '0;
  logic [15:0] speed = '0;
  logic result_valid;
  logic result_ready = 0;
  logic [1:0] status;
  logic signed [17:0] pitch;
  logic [TIME_W-1:0] flight_time;

  ballistic_pitch_solver i_dut (.*);

  initial forever #5 clk = ~clk;

  logic [15:0] grav_m;
  longint pmin_m, pmax_m;
  shot_t shot_q[$];
  aim_t aim_q[$];
  shot_t cur_shot;
  int gap_in = 0, gap_out = 0, watchdog = 0;
  int errors = 0, n_in = 0, n_out = 0;
  bit idle_on = 1;
  int solved_n = 0, bad_n = 0, unreach_n = 0, limit_n = 0;

  const longint atan_tab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
    262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2};

  function automatic longint unsigned isqrt(input logic [127:0] n);
    longint unsigned r, c;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (n >= 128'(c) * 128'(c)) r = c;
    end
    return r;
  endfunction

  function automatic longint rotate_angle(input longint xi, input longint yi);
    longint x, y, mag, z, dx, dy;
    x = xi;
    y = yi;
    z = 0;
    mag = (y < 0) ? -y : y;
    if (x > mag) mag = x;
    while (mag < (64'sd1 <<< 39)) begin
      x = x * 2;
      y = y * 2;
      mag = mag * 2;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_tab[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_tab[i];
      end
    end
    return (z + 128) >>> 8;
  endfunction

  function automatic longint cdeg_to_q16(input longint cdeg);
    longint unsigned m, q;
    m = longint'(cdeg < 0 ? -cdeg : cdeg) * 64'd3454217652357;
    q = (m + 64'd150994944000) / 64'd301989888000;
    return cdeg < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic aim_t solve_shot(input shot_t it);
    aim_t res;
    logic [127:0] v2, gd, gh, pos, neg, big;
    logic [15:0] ah;
    longint unsigned s, ya, r;
    longint y1, y2, yc, p1, p2, lo, hi;
    bit ok1, ok2, take2;
    res = '0;
    if (it.reach == 0 || it.spd == 0 || grav_m == 0) begin
      res.st = ST_BAD;
      return res;
    end
    v2 = 128'(it.spd) * 128'(it.spd);
    gd = 128'(grav_m) * 128'(it.reach);
    ah = it.hgt[15] ? 16'(-it.hgt) : it.hgt;
    gh = 128'(2) * 128'(grav_m) * 128'(ah) * v2;
    if (it.hgt[15]) begin
      pos = v2 * v2 + gh;
      neg = gd * gd;
    end else begin
      pos = v2 * v2;
      neg = gd * gd + gh;
    end
    if (pos < neg) begin
      res.st = ST_UNREACH;
      return res;
    end
    s = isqrt(pos - neg);
    y1 = longint'(v2[63:0] + s);
    y2 = longint'(v2[63:0]) - longint'(s);
    p1 = rotate_angle(longint'(gd[63:0]), y1);
    p2 = rotate_angle(longint'(gd[63:0]), y2);
    lo = cdeg_to_q16(pmin_m);
    hi = cdeg_to_q16(pmax_m);
    ok1 = p1 >= lo && p1 <= hi;
    ok2 = p2 >= lo && p2 <= hi;
    if (!ok1 && !ok2) begin
      res.st = ST_LIMIT;
      return res;
    end
    take2 = (ok1 && ok2) ? ((y2 < 0 ? -y2 : y2) < y1) : ok2;
    yc = take2 ? y2 : y1;
    ya = longint'(yc < 0 ? -yc : yc);
    big = gd * gd + 128'(ya) * 128'(ya);
    r = isqrt(big * 128'd1000000000000) / (64'(grav_m) * 64'(it.spd));
    if (r > 64'hFFFFFF) r = 64'hFFFFFF;
    res.st = ST_OK;
    res.ang = 18'(take2 ? p2 : p1);
    res.tof = r[23:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 0;
    end else begin
      if (item_valid && item_ready) begin
        aim_q.push_back(solve_shot(cur_shot));
        n_in++;
      end
      if (!item_valid || item_ready) begin
        if (gap_in > 0) begin
          gap_in--;
          item_valid <= 0;
        end else if (shot_q.size() > 0) begin
          cur_shot = shot_q.pop_front();
          distance <= cur_shot.reach;
          height <= cur_shot.hgt;
          speed <= cur_shot.spd;
          item_valid <= 1;
          gap_in = pick_gap();
        end else begin
          item_valid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    aim_t e;
    if (rst) begin
      result_ready <= 0;
    end else begin
      if (result_valid && result_ready) begin
        n_out++;
        if (aim_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word: st=%0d pitch=%0d tof=%0d",
                                     status, pitch, flight_time);
        end else begin
          e = aim_q.pop_front();
          case (e.st)
            ST_OK: solved_n++;
            ST_BAD: bad_n++;
            ST_UNREACH: unreach_n++;
            default: limit_n++;
          endcase
          if (status !== e.st || pitch !== e.ang || flight_time !== e.tof) begin
            errors++;
            if (errors <= 10)
              $display("result %0d: exp st=%0d pitch=%0d tof=%0d, got st=%0d pitch=%0d tof=%0d",
                       n_out, e.st, e.ang, e.tof, status, pitch, flight_time);
          end
        end
      end
      if (gap_out > 0) begin
        gap_out--;
        result_ready <= 0;
      end else begin
        result_ready <= 1;
        gap_out = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && item_ready) || (result_valid && result_ready)) watchdog = 0;
      else if (item_valid || shot_q.size() > 0 || aim_q.size() > 0) watchdog++;
      if (watchdog >= WD_LIMIT) begin
        $display("watchdog expired: %0d in, %0d out", n_in, n_out);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      REG_GRAVITY: grav_m = val;
      REG_PITCH_MIN: pmin_m = longint'($signed(val[14:0]));
      default: pmax_m = longint'($signed(val[14:0]));
    endcase
  endtask

  task automatic setup(input logic [15:0] g, input int lo, input int hi);
    write_reg(REG_GRAVITY, g);
    write_reg(REG_PITCH_MIN, 16'(lo));
    write_reg(REG_PITCH_MAX, 16'(hi));
    @(posedge clk);
    cfg_we <= 0;
    repeat (10) @(posedge clk);
  endtask

  function automatic shot_t mk(input int d, input int h, input int v);
    shot_t s;
    s.reach = 16'(d);
    s.hgt = 16'(h);
    s.spd = 16'(v);
    return s;
  endfunction

  function automatic shot_t rand_shot();
    int r;
    shot_t s;
    r = $urandom_range(0, 99);
    s.reach = 16'($urandom);
    s.hgt = 16'($urandom);
    s.spd = 16'($urandom);
    if (r < 55) begin
      s.reach = 16'($urandom_range(1, 40000));
      s.hgt = 16'($urandom_range(0, 16000)) - 16'sd8000;
      s.spd = 16'($urandom_range(20000, 65535));
    end else if (r < 65) begin
      s.spd = 16'($urandom_range(1, 3000));
    end else if (r < 68) begin
      s.reach = 16'd0;
    end else if (r < 71) begin
      s.spd = 16'd0;
    end
    return s;
  endfunction

  task automatic run_phase(input int n);
    for (int i = 0; i < n; i++) shot_q.push_back(rand_shot());
    while (shot_q.size() > 0 || item_valid || aim_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    grav_m = GRAVITY_RST;
    pmin_m = -9000;
    pmax_m = 9000;
    repeat (7) @(posedge clk);
    rst <= 0;
    repeat (5) @(posedge clk);

    shot_q.push_back(mk(0, 0, 5000));
    shot_q.push_back(mk(1000, 0, 0));
    shot_q.push_back(mk(0, 0, 0));
    shot_q.push_back(mk(65535, 32767, 65535));
    shot_q.push_back(mk(65535, -32768, 65535));
    shot_q.push_back(mk(1, 0, 1));
    shot_q.push_back(mk(1, -32768, 1));
    shot_q.push_back(mk(65535, 0, 100));
    shot_q.push_back(mk(9810, 0, 9810));
    shot_q.push_back(mk(1000, 0, 5000));
    shot_q.push_back(mk(1, 32767, 65535));
    shot_q.push_back(mk(65535, 0, 65535));
    shot_q.push_back(mk(30000, -20000, 30000));
    shot_q.push_back(mk(100, 32767, 800));
    run_phase(140);

    idle_on = 0;
    setup(16'd1, -9000, 9000);
    shot_q.push_back(mk(65535, 32767, 1));
    shot_q.push_back(mk(65535, -32768, 65535));
    run_phase(140);
    idle_on = 1;

    setup(16'd65535, 0, 4500);
    shot_q.push_back(mk(65535, 0, 65535));
    run_phase(140);

    setup(16'd9810, 4500, -4500);
    run_phase(120);

    setup(16'd0, -9000, 9000);
    shot_q.push_back(mk(1000, 0, 5000));
    run_phase(40);

    setup(16'd20000, -16384, 16383);
    run_phase(140);

    setup(16'd9810, -1000, 1000);
    run_phase(140);

    setup(16'd3000, -9000, 2000);
    run_phase(140);

    $display("covered %0d words: %0d solved, %0d bad input, %0d unreachable, %0d out of limits",
             n_in, solved_n, bad_n, unreach_n, limit_n);
    $display("eight register settings incl. zero, min and max gravity and crossed limits");
    if (errors == 0 && aim_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, aim_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
